// ===== rtl/core/dep_pkg.sv =====
// Package with the types and encoding constants of the encoded pointer decoder.
`timescale 1ns / 1ps

package dep_pkg;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_PAD     = 3'd1,
        PH_ALIGNED = 3'd2,
        PH_FIXED   = 3'd3,
        PH_LEB     = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_FORMAT = 2'd1,
        ST_BAD_APPL   = 2'd2,
        ST_IDLE_BYTE  = 2'd3
    } status_t;

    typedef struct packed {
        logic [63:0] value;
        logic        needs_indirect;
        status_t     status;
    } result_t;

    localparam logic REQ_BEGIN = 1'b0;

    localparam logic [7:0] ENC_OMIT    = 8'hff;
    localparam logic [7:0] ENC_ALIGNED = 8'h50;

    localparam logic [3:0] FMT_ABSPTR = 4'h0;
    localparam logic [3:0] FMT_ULEB   = 4'h1;
    localparam logic [3:0] FMT_UDATA2 = 4'h2;
    localparam logic [3:0] FMT_UDATA4 = 4'h3;
    localparam logic [3:0] FMT_UDATA8 = 4'h4;
    localparam logic [3:0] FMT_SLEB   = 4'h9;
    localparam logic [3:0] FMT_SDATA2 = 4'ha;
    localparam logic [3:0] FMT_SDATA4 = 4'hb;
    localparam logic [3:0] FMT_SDATA8 = 4'hc;

    localparam logic [2:0] APPL_ABS  = 3'h0;
    localparam logic [2:0] APPL_PC   = 3'h1;
    localparam logic [2:0] APPL_FUNC = 3'h4;

endpackage

// ===== rtl/core/dwarf_encoded_pointer_decoder.sv =====
// Top level of the DWARF exception-header encoded pointer decoder.
//
//  Channel | Prefix | Direction | Carries
//  --------+--------+-----------+----------------------------------------------
//  input   | s_     | in        | begin request or one data byte of the value
//  result  | m_     | out       | decoded pointer, indirect flag and status
//
// The state update and the result are formed in one pass of logic from the state
// registers into the result register or, while a result is held there, the skid register.
// A new request is accepted in every cycle while the skid register is empty.
// The result register and a one-entry skid register decouple the two channels.
// Reset is synchronous and active low; it leaves the decoder idle and empty.
`timescale 1ns / 1ps

module dwarf_encoded_pointer_decoder
    import dep_pkg::*;
#(
    parameter int POINTER_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [7:0]  s_encoding,
    input  logic [63:0] s_value_address,
    input  logic [63:0] s_func_base,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_value,
    output logic        m_needs_indirect,
    output logic [1:0]  m_status
);

    localparam logic [63:0] WordMask   = {64{1'b1}} >> (64 - 8 * POINTER_BYTES);
    localparam logic [3:0]  PtrLen     = 4'(POINTER_BYTES);
    localparam int          RecipShift = 17;
    localparam int          RecipMul   = ((1 << RecipShift) + POINTER_BYTES - 1) / POINTER_BYTES;

    function automatic int unsigned byte_weight(int unsigned idx);
        int unsigned w;
        w = 1;
        for (int unsigned j = 0; j < idx; j++) begin
            w = (w * 256) % POINTER_BYTES;
        end
        return w;
    endfunction

    function automatic result_t finish_value(logic [63:0] raw, logic [7:0] enc,
                                             logic leb_neg, logic [6:0] shift,
                                             logic [63:0] start, logic [63:0] base);
        logic [63:0] v;
        result_t     r;
        v = raw;
        if (enc[3:0] == FMT_SDATA2) begin
            v = {{48{raw[15]}}, raw[15:0]};
        end else if (enc[3:0] == FMT_SDATA4) begin
            v = {{32{raw[31]}}, raw[31:0]};
        end else if (enc[3:0] == FMT_SLEB && leb_neg && !shift[6]) begin
            v = raw | ({64{1'b1}} << shift[5:0]);
        end
        v = v & WordMask;
        r.value          = '0;
        r.needs_indirect = 1'b0;
        r.status         = ST_OK;
        if (v != '0) begin
            priority if (enc[6:4] == APPL_ABS) begin
                r.value          = v;
                r.needs_indirect = enc[7];
            end else if (enc[6:4] == APPL_PC) begin
                r.value          = (v + start) & WordMask;
                r.needs_indirect = enc[7];
            end else if (enc[6:4] == APPL_FUNC) begin
                r.value          = (v + base) & WordMask;
                r.needs_indirect = enc[7];
            end else begin
                r.status = ST_BAD_APPL;
            end
        end
        return r;
    endfunction

    phase_t      phase_reg, phase_next;
    logic [7:0]  held_enc_reg, held_enc_next;
    logic [63:0] start_reg, start_next;
    logic [63:0] func_reg, func_next;
    logic [63:0] acc_reg, acc_next;
    logic [3:0]  bytes_left_reg, bytes_left_next;
    logic [6:0]  bit_shift_reg, bit_shift_next;
    logic [2:0]  pad_left_reg, pad_left_next;

    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;
    logic        skid_valid_reg, skid_valid_next;
    result_t     skid_reg, skid_next;

    logic        accept;
    logic        emit;
    result_t     res;
    logic [63:0] acc_fixed;
    logic [63:0] acc_leb;
    logic [6:0]  fixed_shift;
    logic [6:0]  leb_shift;

    logic [10:0] byte_term [8];
    logic [13:0] res_sum;
    logic [31:0] res_prod;
    logic [11:0] res_quot;
    logic [13:0] res_back;
    logic [2:0]  res_rem;
    logic [2:0]  pad_init;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;

    // Address residue modulo the pointer size, from weighted address bytes.
    for (genvar g = 0; g < 8; g++) begin : g_byte
        localparam logic [2:0] Weight = 3'(byte_weight(g));
        assign byte_term[g] = 11'(s_value_address[8 * g +: 8]) * 11'(Weight);
    end

    always_comb begin
        res_sum = '0;
        for (int i = 0; i < 8; i++) begin
            res_sum = res_sum + 14'(byte_term[i]);
        end
        res_prod = 32'(res_sum) * 32'(RecipMul);
        res_quot = 12'(res_prod >> RecipShift);
        res_back = 14'(res_quot) * 14'(POINTER_BYTES);
        res_rem  = 3'(res_sum - res_back);
        pad_init = (res_rem == 3'd0) ? 3'd0 : 3'(PtrLen - {1'b0, res_rem});
    end

    always_comb begin
        acc_fixed   = acc_reg | (bit_shift_reg[6] ? 64'd0 :
                                 ({56'd0, s_data_byte} << bit_shift_reg[5:0]));
        acc_leb     = acc_reg | (bit_shift_reg[6] ? 64'd0 :
                                 ({57'd0, s_data_byte[6:0]} << bit_shift_reg[5:0]));
        fixed_shift = bit_shift_reg + 7'd8;
        leb_shift   = bit_shift_reg[6] ? bit_shift_reg : bit_shift_reg + 7'd7;
    end

    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            if (s_req_type == REQ_BEGIN) begin
                priority if (s_encoding == ENC_OMIT) begin
                    phase_next = PH_IDLE;
                end else if (s_encoding == ENC_ALIGNED) begin
                    phase_next = (pad_init != 3'd0) ? PH_PAD : PH_ALIGNED;
                end else begin
                    unique case (s_encoding[3:0])
                        FMT_ABSPTR, FMT_UDATA2, FMT_UDATA4, FMT_UDATA8,
                        FMT_SDATA2, FMT_SDATA4, FMT_SDATA8: phase_next = PH_FIXED;
                        FMT_ULEB, FMT_SLEB: phase_next = PH_LEB;
                        default: phase_next = PH_IDLE;
                    endcase
                end
            end else begin
                unique case (phase_reg)
                    PH_PAD: begin
                        if (pad_left_reg == 3'd1) begin
                            phase_next = PH_ALIGNED;
                        end
                    end
                    PH_ALIGNED, PH_FIXED: begin
                        if (bytes_left_reg == 4'd1) begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_LEB: begin
                        if (!s_data_byte[7]) begin
                            phase_next = PH_IDLE;
                        end
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
        end
    end

    always_comb begin
        held_enc_next   = held_enc_reg;
        start_next      = start_reg;
        func_next       = func_reg;
        acc_next        = acc_reg;
        bytes_left_next = bytes_left_reg;
        bit_shift_next  = bit_shift_reg;
        pad_left_next   = pad_left_reg;
        emit            = 1'b0;
        res.value          = '0;
        res.needs_indirect = 1'b0;
        res.status         = ST_OK;
        if (accept) begin
            if (s_req_type == REQ_BEGIN) begin
                held_enc_next   = s_encoding;
                start_next      = s_value_address;
                func_next       = s_func_base;
                acc_next        = '0;
                bytes_left_next = '0;
                bit_shift_next  = '0;
                pad_left_next   = '0;
                priority if (s_encoding == ENC_OMIT) begin
                    emit = 1'b1;
                end else if (s_encoding == ENC_ALIGNED) begin
                    pad_left_next   = pad_init;
                    bytes_left_next = PtrLen;
                end else begin
                    unique case (s_encoding[3:0])
                        FMT_ABSPTR: bytes_left_next = PtrLen;
                        FMT_UDATA2, FMT_SDATA2: bytes_left_next = 4'd2;
                        FMT_UDATA4, FMT_SDATA4: bytes_left_next = 4'd4;
                        FMT_UDATA8, FMT_SDATA8: bytes_left_next = 4'd8;
                        FMT_ULEB, FMT_SLEB: bytes_left_next = '0;
                        default: begin
                            emit       = 1'b1;
                            res.status = ST_BAD_FORMAT;
                        end
                    endcase
                end
            end else begin
                unique case (phase_reg)
                    PH_PAD: pad_left_next = pad_left_reg - 3'd1;
                    PH_ALIGNED, PH_FIXED: begin
                        acc_next        = acc_fixed;
                        bit_shift_next  = fixed_shift;
                        bytes_left_next = bytes_left_reg - 4'd1;
                        if (bytes_left_reg == 4'd1) begin
                            emit = 1'b1;
                            if (phase_reg == PH_ALIGNED) begin
                                res.value = acc_fixed & WordMask;
                            end else begin
                                res = finish_value(acc_fixed, held_enc_reg, 1'b0,
                                                   fixed_shift, start_reg, func_reg);
                            end
                        end
                    end
                    PH_LEB: begin
                        acc_next       = acc_leb;
                        bit_shift_next = leb_shift;
                        if (!s_data_byte[7]) begin
                            emit = 1'b1;
                            res  = finish_value(acc_leb, held_enc_reg, s_data_byte[6],
                                                leb_shift, start_reg, func_reg);
                        end
                    end
                    default: begin
                        emit       = 1'b1;
                        res.status = ST_IDLE_BYTE;
                    end
                endcase
            end
        end
    end

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg) begin
            out_valid_next = emit;
            out_next       = res;
        end else if (m_ready) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = emit;
                out_next       = res;
            end
        end else if (emit) begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            bytes_left_reg <= '0;
            bit_shift_reg  <= '0;
            pad_left_reg   <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            bit_shift_reg  <= bit_shift_next;
            pad_left_reg   <= pad_left_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_enc_reg <= held_enc_next;
        start_reg    <= start_next;
        func_reg     <= func_next;
        acc_reg      <= acc_next;
        out_reg      <= out_next;
        skid_reg     <= skid_next;
    end

    assign m_valid          = out_valid_reg;
    assign m_value          = out_reg.value;
    assign m_needs_indirect = out_reg.needs_indirect;
    assign m_status         = out_reg.status;

    // The skid register only fills behind a waiting result.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while the result register is empty");

    a_pad_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAD) |-> (pad_left_reg != 3'd0))
        else $error("padding phase entered with no padding bytes left");

    a_bytes_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_FIXED || phase_reg == PH_ALIGNED) |-> (bytes_left_reg != 4'd0))
        else $error("fixed-size read active with no bytes left");

    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_value == '0 && !m_needs_indirect))
        else $error("error result carries a value or indirect flag");

    a_omit_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_req_type == REQ_BEGIN && s_encoding == ENC_OMIT) |=> m_valid)
        else $error("omitted pointer request gave no result");

endmodule
